>>> hdl/video_line_sync_burst_classifier_assert.svh
// Assertion macros shared by the video line sync and burst classifier RTL.
`ifndef VIDEO_LINE_SYNC_BURST_CLASSIFIER_ASSERT_SVH
`define VIDEO_LINE_SYNC_BURST_CLASSIFIER_ASSERT_SVH
`ifndef SYNTH
`define VLSBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define VLSBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VLSBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define VLSBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/vlsbc_pkg.sv
// Package with types and constants of the video line sync and burst classifier.
`default_nettype none
package vlsbc_pkg;

	typedef logic [1:0] pulse_kind_t;

	localparam pulse_kind_t KIND_H     = 2'd0;
	localparam pulse_kind_t KIND_EQ    = 2'd1;
	localparam pulse_kind_t KIND_BROAD = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_VIDEO_STANDARD = 2'd0;
	localparam logic [1:0] REG_NOMINAL_LINE   = 2'd1;
	localparam logic [1:0] REG_SOURCE_ROW_OFS = 2'd2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [11:0] NOMINAL_LINE_RESET = 12'd1135;

	// Field windows of the active picture.
	localparam logic [9:0] PAL_F1_FIRST  = 10'd23;
	localparam logic [9:0] PAL_F2_FIRST  = 10'd335;
	localparam logic [9:0] PAL_PER_FIELD = 10'd288;
	localparam logic [9:0] NTSC_F1_FIRST  = 10'd22;
	localparam logic [9:0] NTSC_F2_FIRST  = 10'd284;
	localparam logic [9:0] NTSC_PER_FIELD = 10'd240;

	// Colour burst blanking for each PAL sequence field.
	function automatic logic pal_blanked(input logic [9:0] line, input logic [1:0] seq);
		logic b;
		unique case (seq)
			2'd0: b = (line >= 10'd623) || (line <= 10'd6);
			2'd1: b = (line >= 10'd310) && (line <= 10'd318);
			2'd2: b = (line >= 10'd622) || (line <= 10'd5);
			default: b = (line >= 10'd311) && (line <= 10'd319);
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

>>> hdl/video_line_sync_burst_classifier.sv
// An accepted line descriptor passes the input register, then the result
// register. Throughput: one descriptor per cycle while out_ready keeps the
// result register moving; the decode is one registered pass between them.
// A stalled result register holds its transaction while the input register
// still fills, so the two sides are decoupled by one stage.
// Reset: arst_n clears the valid flags and restores the register defaults.
`default_nettype none
module video_line_sync_burst_classifier (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration port.
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vlsbc_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [vlsbc_pkg::PDATA_W-1:0]   pwdata,
	output logic      [vlsbc_pkg::PDATA_W-1:0]   prdata,
	output logic                                 pready,
	// Line descriptor channel.
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            frame_parity,
	input  wire logic [9:0]                      line_number,
	input  wire logic [1:0]                      field_number,
	input  wire logic [1:0]                      base_pulse_kind,
	input  wire logic                            base_two_half_pulses,
	input  wire logic                            table_burst_enable,
	input  wire logic                            active_picture_line,
	// Result channel.
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           first_pulse_kind,
	output logic                                 second_pulse_present,
	output logic [1:0]                           second_pulse_kind,
	output logic [12:0]                          line_sample_count,
	output logic [11:0]                          half_line_offset,
	output logic [1:0]                           color_sequence,
	output logic                                 burst_enable,
	output logic                                 burst_phase_positive,
	output logic                                 v_axis_invert,
	output logic                                 active_valid,
	output logic [9:0]                           active_row,
	output logic [11:0]                          image_row
);
	import vlsbc_pkg::*;
	`include "video_line_sync_burst_classifier_assert.svh"

	// Configuration registers.
	logic        video_standard_q;
	logic [11:0] nominal_line_samples_q;
	logic [10:0] row_offset_q;
	logic [1:0]  reg_index;
	logic        cfg_write;

	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_standard_q       <= 1'b0;
			nominal_line_samples_q <= NOMINAL_LINE_RESET;
			row_offset_q           <= '0;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_VIDEO_STANDARD: video_standard_q       <= pwdata[0];
				REG_NOMINAL_LINE:   nominal_line_samples_q <= pwdata[11:0];
				REG_SOURCE_ROW_OFS: row_offset_q           <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_VIDEO_STANDARD: prdata = {31'd0, video_standard_q};
			REG_NOMINAL_LINE:   prdata = {20'd0, nominal_line_samples_q};
			REG_SOURCE_ROW_OFS: prdata = {21'd0, row_offset_q};
			default:            prdata = '0;
		endcase
	end

	// Handshake of the two stages.
	logic v_s1;
	logic v_s2;
	logic adv_s1;

	assign adv_s1   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s1;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_s1) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Input register.
	logic        parity_s1;
	logic [9:0]  line_s1;
	logic [1:0]  field_s1;
	logic [1:0]  base_s1;
	logic        two_s1;
	logic        tburst_s1;
	logic        active_pic_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			parity_s1     <= frame_parity;
			line_s1       <= line_number;
			field_s1      <= field_number;
			base_s1       <= base_pulse_kind;
			two_s1        <= base_two_half_pulses;
			tburst_s1     <= table_burst_enable;
			active_pic_s1 <= active_picture_line;
		end
	end

	// Line decode.
	logic        pal;
	pulse_kind_t base;
	pulse_kind_t k1;
	pulse_kind_t k2;
	logic        has2;
	logic        overridden;
	logic [12:0] count;
	logic [13:0] count_inc;
	logic [11:0] half;
	logic [1:0]  seq_raw;
	logic [1:0]  seq;
	logic        burst;
	logic        pos;
	logic        vinv;
	logic        pos_odd;
	logic [9:0]  f1_first;
	logic [9:0]  f2_first;
	logic [9:0]  per_field;
	logic [9:0]  fl;
	logic        in_f1;
	logic        in_f2;
	logic        valid;
	logic [9:0]  row;
	logic [11:0] srow;

	assign pal  = !video_standard_q;
	assign base = (base_s1 == 2'd3) ? KIND_BROAD : base_s1;

	always_comb begin
		k1         = base;
		k2         = KIND_H;
		has2       = 1'b0;
		overridden = 1'b1;
		priority if (pal && (line_s1 == 10'd1 || line_s1 == 10'd2 ||
				line_s1 == 10'd314 || line_s1 == 10'd315)) begin
			k1 = KIND_BROAD; k2 = KIND_BROAD; has2 = 1'b1;
		end else if (pal && line_s1 == 10'd3) begin
			k1 = KIND_BROAD; k2 = KIND_EQ; has2 = 1'b1;
		end else if (pal && line_s1 == 10'd313) begin
			k1 = KIND_EQ; k2 = KIND_BROAD; has2 = 1'b1;
		end else if (pal && (line_s1 == 10'd6 || line_s1 == 10'd318)) begin
			k1 = KIND_EQ;
		end else if (pal && (line_s1 == 10'd4 || line_s1 == 10'd5 ||
				line_s1 == 10'd311 || line_s1 == 10'd312 ||
				line_s1 == 10'd316 || line_s1 == 10'd317 ||
				line_s1 == 10'd623 || line_s1 == 10'd624 ||
				line_s1 == 10'd625)) begin
			k1 = KIND_EQ; k2 = KIND_EQ; has2 = 1'b1;
		end else if (!pal && line_s1 == 10'd263) begin
			k1 = KIND_H; k2 = KIND_EQ; has2 = 1'b1;
		end else begin
			overridden = 1'b0;
		end
		if (!overridden && two_s1) begin
			k2   = base;
			has2 = 1'b1;
			// NTSC field 2 vertical interval starts on a half line.
			if (!pal) begin
				priority if (line_s1 == 10'd266) begin
					k1 = KIND_EQ; k2 = KIND_BROAD;
				end else if (line_s1 == 10'd269) begin
					k1 = KIND_BROAD; k2 = KIND_EQ;
				end else if (line_s1 == 10'd272) begin
					k1 = KIND_EQ; k2 = KIND_H; has2 = 1'b0;
				end else begin
				end
			end
		end
	end

	always_comb begin
		count = {1'b0, nominal_line_samples_q};
		if (pal && (line_s1 == 10'd313 || line_s1 == 10'd625)) begin
			count = {1'b0, nominal_line_samples_q} + 13'd2;
		end
	end

	assign count_inc = {1'b0, count} + 14'd1;
	assign half      = count_inc[12:1];

	assign seq_raw = {parity_s1, 1'b0} + field_s1 + 2'd3;
	assign pos_odd = (seq_raw == 2'd0) || (seq_raw == 2'd1);

	always_comb begin
		if (pal) begin
			seq   = seq_raw;
			burst = (base == KIND_H) && !pal_blanked(line_s1, seq_raw);
			pos   = line_s1[0] ? pos_odd : !pos_odd;
			vinv  = !pos;
		end else begin
			seq   = 2'd0;
			burst = tburst_s1;
			pos   = 1'b0;
			vinv  = 1'b0;
		end
	end

	assign f1_first  = pal ? PAL_F1_FIRST : NTSC_F1_FIRST;
	assign f2_first  = pal ? PAL_F2_FIRST : NTSC_F2_FIRST;
	assign per_field = pal ? PAL_PER_FIELD : NTSC_PER_FIELD;

	assign in_f1 = (line_s1 >= f1_first) && (line_s1 < f1_first + per_field);
	assign in_f2 = (line_s1 >= f2_first) && (line_s1 < f2_first + per_field);

	always_comb begin
		valid = 1'b0;
		fl    = '0;
		row   = '0;
		srow  = '0;
		if (base == KIND_H && active_pic_s1) begin
			if (in_f1) begin
				valid = 1'b1;
				fl    = line_s1 - f1_first;
				row   = fl;
			end else if (in_f2) begin
				valid = 1'b1;
				fl    = line_s1 - f2_first;
				row   = per_field + fl;
			end
			if (valid) begin
				srow = {1'b0, row_offset_q} + {1'b0, fl, 1'b0}
					+ {11'd0, field_s1 == 2'd1};
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (adv_s1 && v_s1) begin
			first_pulse_kind     <= k1;
			second_pulse_present <= has2;
			second_pulse_kind    <= k2;
			line_sample_count    <= count;
			half_line_offset     <= half;
			color_sequence       <= seq;
			burst_enable         <= burst;
			burst_phase_positive <= pos;
			v_axis_invert        <= vinv;
			active_valid         <= valid;
			active_row           <= row;
			image_row            <= srow;
		end
	end

	`VLSBC_ASSERT_NEXT(a_capture, clk, arst_n, in_valid && in_ready, v_s1,
		"accepted transaction not held in input stage")
	`VLSBC_ASSERT_IMP(a_no_second, clk, arst_n, out_valid && !second_pulse_present,
		second_pulse_kind == KIND_H, "absent second pulse has nonzero kind")
	`VLSBC_ASSERT_IMP(a_inactive_rows, clk, arst_n, out_valid && !active_valid,
		active_row == 10'd0 && image_row == 12'd0, "inactive line carries rows")
	`VLSBC_ASSERT_IMP(a_phase_excl, clk, arst_n, out_valid,
		!(burst_phase_positive && v_axis_invert), "burst phase and V switch both set")

endmodule
`default_nettype wire
